### design/lmtf_pkg.sv
`timescale 1ns / 1ps

package lmtf_pkg;

    // Field widths fixed by the block's interface.
    localparam int KEY_W = 64;
    localparam int POS_W = 3;

    // Action codes.
    localparam logic ACT_REFERENCE = 1'b0;
    localparam logic ACT_QUERY     = 1'b1;

    // Write data sources for the entry store.
    localparam logic WSEL_KEY_IN = 1'b0;
    localparam logic WSEL_CARRY  = 1'b1;

    // Command beat.
    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] key_in;
    } cmd_t;

    // Result beat.
    typedef struct packed {
        logic [KEY_W-1:0] key_out;
        logic [POS_W-1:0] position;
        logic             last;
    } result_t;

    // Per-cycle controls from the sequencer to the datapath.
    typedef struct packed {
        logic we;        // write the entry store
        logic wsel;      // write data source
        logic carry_ld;  // capture the entry just read as the next carry
        logic emit;      // present a result beat next cycle
        logic emit_last; // that beat closes the query run
    } ctrl_t;

endpackage

### design/lru_move_to_front_list_core.sv
// Reference: into an empty list the key is written at acceptance, without going busy;
// else one entry of the store is read, compared and rewritten per cycle in ST_REF,
// then ST_TAIL on a miss below capacity. Query: one result beat per stored key, one per cycle.
// An empty list on query gives no beats and leaves the block idle.
// Results cannot be stalled. Asynchronous active-low reset empties the list.
`timescale 1ns / 1ps

module lru_move_to_front_list_core
    import lmtf_pkg::*;
#(
    parameter int CAPACITY = 5,
    parameter int KEY_BITS = 64
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    result_valid,
    output result_t result
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    ctrl_t               ctrl;
    logic [IW-1:0]       waddr, raddr, pos;
    logic [KEY_BITS-1:0] key_reg, carry_reg, rd_data, wr_data, key_masked;
    logic                start_acc, hit;
    logic                valid_reg;
    result_t             result_reg;

    assign start_acc  = start && !busy;
    assign key_masked = cmd.key_in[KEY_BITS-1:0];

    // The shared compare unit.
    assign hit     = (rd_data == key_reg);
    assign wr_data = (ctrl.wsel == WSEL_KEY_IN) ? key_masked : carry_reg;

    lmtf_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start_acc (start_acc),
        .action    (cmd.action),
        .hit       (hit),
        .busy      (busy),
        .ctrl      (ctrl),
        .waddr     (waddr),
        .raddr     (raddr),
        .pos       (pos)
    );

    lmtf_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.we),
        .waddr (waddr),
        .wdata (wr_data),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // Key under reference and the key being pushed down the list.
    always_ff @(posedge clk)
    begin
        if (start_acc)
        begin
            key_reg   <= key_masked;
            carry_reg <= key_masked;
        end
        else if (ctrl.carry_ld)
        begin
            carry_reg <= rd_data;
        end
    end

    // Result beat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctrl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            result_reg.key_out  <= KEY_W'(rd_data);
            result_reg.position <= POS_W'(pos);
            result_reg.last     <= ctrl.emit_last;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // A beat only follows a busy cycle.
    a_beat_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result beat without a preceding busy cycle");

    // The closing beat of a query finds the block free again.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy)
        else $error("block still busy at the closing beat");

    // A query run has no gaps.
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |=> result_valid)
        else $error("gap inside a query run");

    // Positions count up by one within a run.
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |=>
            (result.position == $past(result.position) + 3'd1))
        else $error("position did not advance by one");
`endif

endmodule

### design/lmtf_ram.sv
`timescale 1ns / 1ps

module lmtf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 5,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [AW-1:0]            raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/lmtf_ctrl.sv
`timescale 1ns / 1ps

module lmtf_ctrl
    import lmtf_pkg::*;
#(
    parameter int CAPACITY = 5,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start_acc,
    input  logic          action,
    input  logic          hit,
    output logic          busy,
    output ctrl_t         ctrl,
    output logic [IW-1:0] waddr,
    output logic [IW-1:0] raddr,
    output logic [IW-1:0] pos
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_REF  = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;
    localparam logic [1:0] ST_QRY  = 2'd3;

    localparam logic [IW-1:0] IDX_LAST = IW'(CAPACITY - 1);

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] idx_inc;
    logic          at_tail;

    // Next read address wraps at the end of the store; the data is unused then.
    assign idx_inc = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign at_tail = (CW'(idx_reg) + 1'b1) == count_reg;
    assign busy    = (state_reg != ST_IDLE);
    assign pos     = idx_reg;

    // Sequencer: on a reference one entry is read, compared and rewritten each cycle; a query only reads.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        ctrl       = '0;
        ctrl.wsel  = WSEL_CARRY;
        waddr      = idx_reg;
        raddr      = idx_inc;
        unique case (state_reg)
            ST_IDLE:
            begin
                raddr    = '0;
                idx_next = '0;
                if (start_acc)
                begin
                    if (action == ACT_QUERY)
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = ST_QRY;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // First key goes straight to the front.
                        ctrl.we    = 1'b1;
                        ctrl.wsel  = WSEL_KEY_IN;
                        waddr      = '0;
                        count_next = CW'(1);
                    end
                    else
                    begin
                        state_next = ST_REF;
                    end
                end
            end
            ST_REF:
            begin
                // Write the carried key here and pick up the one it displaces.
                ctrl.we       = 1'b1;
                ctrl.carry_ld = 1'b1;
                if (hit || (idx_reg == IDX_LAST))
                begin
                    state_next = ST_IDLE;
                end
                else if (at_tail)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_TAIL:
            begin
                // Miss below capacity: the old last key lands one place further.
                ctrl.we    = 1'b1;
                waddr      = IW'(count_reg);
                count_next = count_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_QRY:
            begin
                ctrl.emit      = 1'b1;
                ctrl.emit_last = at_tail;
                if (at_tail)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

endmodule
